>>> hw/rtl/fir_pkg.sv
// Shared constants, types and control store for the FIR filter block.
package fir_pkg;

    localparam int TAPS   = 64;
    localparam int TAPS_W = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int SMP_W  = 16;
    localparam int COEF_W = 16;
    localparam int IDX_W  = 6;
    localparam int PROD_W = SMP_W + COEF_W;
    localparam int ACC_W  = 40;
    localparam int FRAC_W = 15;

    // Sequencer step addresses
    typedef logic [2:0] t_step;
    localparam t_step S_WAIT = 3'd0;
    localparam t_step S_MAC  = 3'd1;
    localparam t_step S_DRN1 = 3'd2;
    localparam t_step S_DRN2 = 3'd3;
    localparam t_step S_FIN  = 3'd4;

    // Jump conditions: jump to nxt when true, else repeat the step
    typedef enum logic [1:0] {
        C_FILT_REQ = 2'd0,
        C_K_LAST   = 2'd1,
        C_ALWAYS   = 2'd2,
        C_OUT_FREE = 2'd3
    } t_cond;

    typedef struct packed {
        logic  take;  // open the request channel
        logic  rd;    // read one tap pair and advance the tap counter
        logic  fin;   // round, saturate and load the output register
        t_cond cond;
        t_step nxt;
    } t_uword;

    function automatic t_uword fir_ucode(input t_step s);
        t_uword w;
        case (s)
            S_WAIT:  w = '{take: 1'b1, rd: 1'b0, fin: 1'b0, cond: C_FILT_REQ, nxt: S_MAC};
            S_MAC:   w = '{take: 1'b0, rd: 1'b1, fin: 1'b0, cond: C_K_LAST,   nxt: S_DRN1};
            S_DRN1:  w = '{take: 1'b0, rd: 1'b0, fin: 1'b0, cond: C_ALWAYS,   nxt: S_DRN2};
            S_DRN2:  w = '{take: 1'b0, rd: 1'b0, fin: 1'b0, cond: C_ALWAYS,   nxt: S_FIN};
            S_FIN:   w = '{take: 1'b0, rd: 1'b0, fin: 1'b1, cond: C_OUT_FREE, nxt: S_WAIT};
            default: w = '{take: 1'b0, rd: 1'b0, fin: 1'b0, cond: C_ALWAYS,   nxt: S_WAIT};
        endcase
        return w;
    endfunction

endpackage

>>> hw/rtl/fir_filter_circular_buffer_core.sv
// Sample filter item: accepted in S_WAIT, then TAPS read/MAC steps, two drain steps and one
// output step (S_FIN) that stalls until the output register is free, before requests are taken
// again; the result goes to the output register and may wait there while a new one is taken.
// Coefficient write: no result. Rate is set by the single multiplier, one tap a cycle.
// Synchronous active-low reset clears the sequencer, write pointer, accumulator and the
// per-entry valid bits, so both stores read as zero at once.
module fir_filter_circular_buffer_core
    import fir_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic                     i_func,
    input  logic signed [SMP_W-1:0]  i_sample_in,
    input  logic        [IDX_W-1:0]  i_coef_index,
    input  logic signed [COEF_W-1:0] i_coef_value,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [SMP_W-1:0]  o_filtered_sample
);

    localparam logic signed [ACC_W-1:0] L_MAX = ACC_W'(2 ** (SMP_W - 1) - 1);
    localparam logic signed [ACC_W-1:0] L_MIN = ~L_MAX;
    localparam logic signed [ACC_W-1:0] L_RND = ACC_W'(2 ** FRAC_W - 1);
    localparam logic [TAPS_W-1:0]       L_LAST = TAPS_W'(TAPS - 1);

    t_step r_step, n_step;
    t_uword w_uw;

    logic [TAPS_W-1:0] r_wp, n_wp, w_wp_inc;
    logic [TAPS_W-1:0] r_k, n_k;
    logic [TAPS_W:0]   w_diff;
    logic [TAPS_W-1:0] w_smp_addr;

    logic signed [SMP_W-1:0]  r_smp_mem  [TAPS];
    logic signed [COEF_W-1:0] r_coef_mem [TAPS];
    logic [TAPS-1:0]          r_smp_vld;
    logic [TAPS-1:0]          r_coef_vld;

    logic signed [SMP_W-1:0]  r_smp_rd;
    logic signed [COEF_W-1:0] r_coef_rd;
    logic                     r_smp_rd_ok;
    logic                     r_coef_rd_ok;
    logic                     r_rd_v;
    logic                     r_prod_v;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc, n_acc;

    logic signed [SMP_W-1:0]  w_smp_op;
    logic signed [COEF_W-1:0] w_coef_op;
    logic signed [ACC_W-1:0]  w_acc_adj;
    logic signed [ACC_W-1:0]  w_quo;
    logic signed [SMP_W-1:0]  w_sat;

    logic r_out_valid;
    logic signed [SMP_W-1:0] r_out_data;

    logic w_in_acc, w_filt, w_cwr, w_out_free, w_cond_ok, w_out_load;

    assign w_uw       = fir_ucode(r_step);
    assign o_in_ready = w_uw.take;
    assign w_in_acc   = i_in_valid & o_in_ready;
    assign w_filt     = w_in_acc & ~i_func;
    assign w_cwr      = w_in_acc & i_func & (int'(i_coef_index) < TAPS);
    assign w_out_free = ~r_out_valid | i_out_ready;
    assign w_out_load = w_uw.fin & w_out_free;

    always_comb begin
        case (w_uw.cond)
            C_FILT_REQ: w_cond_ok = w_filt;
            C_K_LAST:   w_cond_ok = (r_k == L_LAST);
            C_ALWAYS:   w_cond_ok = 1'b1;
            C_OUT_FREE: w_cond_ok = w_out_free;
            default:    w_cond_ok = 1'b0;
        endcase
        n_step = w_cond_ok ? w_uw.nxt : r_step;
    end

    // Ring position of the sample k steps old
    assign w_wp_inc   = (r_wp == L_LAST) ? '0 : r_wp + 1'b1;
    assign w_diff     = {1'b0, r_wp} - {1'b0, r_k};
    assign w_smp_addr = w_diff[TAPS_W] ? TAPS_W'(w_diff + (TAPS_W + 1)'(TAPS))
                                       : w_diff[TAPS_W-1:0];

    always_comb begin
        n_wp = w_filt ? w_wp_inc : r_wp;
        if (w_filt) begin
            n_k = '0;
        end else if (w_uw.rd) begin
            n_k = (r_k == L_LAST) ? '0 : r_k + 1'b1;
        end else begin
            n_k = r_k;
        end
        if (w_filt) begin
            n_acc = '0;
        end else if (r_prod_v) begin
            n_acc = r_acc + ACC_W'(r_prod);
        end else begin
            n_acc = r_acc;
        end
    end

    // Unwritten entries read as zero
    assign w_smp_op  = r_smp_rd_ok  ? r_smp_rd  : '0;
    assign w_coef_op = r_coef_rd_ok ? r_coef_rd : '0;

    // Divide by 2^15 toward zero, then clamp
    assign w_acc_adj = r_acc + (r_acc[ACC_W-1] ? L_RND : '0);
    assign w_quo     = w_acc_adj >>> FRAC_W;
    always_comb begin
        if (w_quo > L_MAX) begin
            w_sat = SMP_W'(L_MAX);
        end else if (w_quo < L_MIN) begin
            w_sat = SMP_W'(L_MIN);
        end else begin
            w_sat = SMP_W'(w_quo);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= S_WAIT;
            r_wp        <= '0;
            r_k         <= '0;
            r_acc       <= '0;
            r_rd_v      <= 1'b0;
            r_prod_v    <= 1'b0;
            r_smp_vld   <= '0;
            r_coef_vld  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_step   <= n_step;
            r_wp     <= n_wp;
            r_k      <= n_k;
            r_acc    <= n_acc;
            r_rd_v   <= w_uw.rd;
            r_prod_v <= r_rd_v;
            if (w_filt) begin
                r_smp_vld[w_wp_inc] <= 1'b1;
            end
            if (w_cwr) begin
                r_coef_vld[TAPS_W'(i_coef_index)] <= 1'b1;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Stores and datapath registers
    always_ff @(posedge i_clk) begin
        if (w_filt) begin
            r_smp_mem[w_wp_inc] <= i_sample_in;
        end
        if (w_cwr) begin
            r_coef_mem[TAPS_W'(i_coef_index)] <= i_coef_value;
        end
        if (w_uw.rd) begin
            r_smp_rd     <= r_smp_mem[w_smp_addr];
            r_coef_rd    <= r_coef_mem[r_k];
            r_smp_rd_ok  <= r_smp_vld[w_smp_addr];
            r_coef_rd_ok <= r_coef_vld[r_k];
        end
        if (r_rd_v) begin
            r_prod <= w_smp_op * w_coef_op;
        end
        if (w_out_load) begin
            r_out_data <= w_sat;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_filtered_sample = r_out_data;

endmodule

>>> hw/rtl/fir_checker.sv
// Port-level checks for the FIR filter core, bound to fir_filter_circular_buffer_core.
module fir_checker
    import fir_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     o_in_ready,
    input logic                     i_func,
    input logic                     o_out_valid,
    input logic                     i_out_ready,
    input logic signed [SMP_W-1:0]  o_filtered_sample
);

    // Hold a result until it is taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before it was taken");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_filtered_sample))
        else $error("stalled result changed");

    // A filter request occupies the datapath
    a_filt_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !i_func |=> !o_in_ready)
        else $error("request taken while a sample is being filtered");

    // A coefficient write does not hold the request channel
    a_cwr_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_func |=> o_in_ready)
        else $error("coefficient write held the request channel");

    // A new result appears only as the sequencer returns to accept requests
    a_out_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> o_in_ready)
        else $error("result raised while the sequencer was busy");

endmodule

bind fir_filter_circular_buffer_core fir_checker u_fir_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in_valid),
    .o_in_ready        (o_in_ready),
    .i_func            (i_func),
    .o_out_valid       (o_out_valid),
    .i_out_ready       (i_out_ready),
    .o_filtered_sample (o_filtered_sample)
);
